FILE: sv/tped_pkg.sv
// Package for the tracker pattern entry decoder.
// Holds the cell, result and tracking-state types, command codes and the effect table.
// No dependencies.
package tped_pkg;

    localparam int CELLS_PER_PATTERN = 256;
    localparam int CNT_W             = $clog2(CELLS_PER_PATTERN);
    localparam int PADDR_W           = 3;

    localparam logic [PADDR_W-1:0] ADDR_SPEED_MODE = '0;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NOTE = 2'd1;
    localparam logic [1:0] KIND_CUT  = 2'd2;

    localparam logic [7:0] NOTE_CUT_A = 8'hFE;
    localparam logic [7:0] NOTE_CUT_B = 8'hFC;
    localparam logic [7:0] NOTE_BASE  = 8'd37;

    localparam logic [6:0] VOL_MAX      = 7'd64;
    localparam logic [5:0] ROW_MIN_INIT = 6'd63;

    localparam logic [3:0] FX_NONE     = 4'd0;
    localparam logic [3:0] FX_SPEED    = 4'd1;
    localparam logic [3:0] FX_JUMP     = 4'd2;
    localparam logic [3:0] FX_BREAK    = 4'd3;
    localparam logic [3:0] FX_VOLSLIDE = 4'd4;
    localparam logic [3:0] FX_TREMOR   = 4'd9;
    localparam logic [3:0] FX_ARPEGGIO = 4'd10;

    typedef struct packed {
        logic [7:0] effect_param;
        logic [7:0] vol_cmd_byte;
        logic [7:0] instr_vol_byte;
        logic [7:0] note_byte;
    } cell_t;

    typedef struct packed {
        logic [1:0] note_kind;
        logic [7:0] note_number;
        logic [4:0] instrument;
        logic       volume_present;
        logic [6:0] volume;
        logic [3:0] command;
        logic [7:0] command_param;
        logic       pattern_end;
        logic       jump_valid;
        logic [7:0] jump_order;
        logic [5:0] jump_row;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] cell_cnt;
        logic [5:0]       break_row_min;
        logic [7:0]       jump_target;
        logic             jump_seen;
    } track_state_t;

    // Effect letter index to command; indices above arpeggio map to none.
    function automatic logic [3:0] effect_lookup(input logic [3:0] idx);
        logic [3:0] cmd;
        cmd = (idx <= FX_ARPEGGIO) ? idx : FX_NONE;
        return cmd;
    endfunction

endpackage

FILE: sv/tracker_pattern_entry_decoder_top.sv
// Top level of the tracker pattern entry decoder: stream channels, APB register.
// Depends on tped_pkg and tped_decode.
//
// Usage:
//   s_axis carries one four-byte pattern cell per transaction; m_axis returns one
//   decoded cell per transaction, with tlast on the last cell of each pattern of
//   CELLS_PER_PATTERN cells. On that cell the jump fields report the last
//   position jump and the lowest break row after it.
//   Pipeline: a cell accepted on s_axis is held in the input register, then
//   decoded into the result register, where m_axis_tvalid rises; the m_axis
//   transaction follows from the result register.
//   Throughput: one cell per cycle while m_axis_tready stays high; the decode is one short combinational pass.
//   Stall: when m_axis_tready is low the result register holds, the input
//   register still takes one more cell if it is empty, then s_axis_tready drops.
//   Reset (aresetn low, synchronous): both stages empty, cell count 0, break row
//   minimum 63, no jump seen, speed_divide_mode 0.
//   The APB register speed_divide_mode at address 0 must be written only while idle; the block does not enforce this.
module tracker_pattern_entry_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tped_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input cells
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // note_byte, instr_vol_byte, vol_cmd_byte, effect_param
    input  logic [31:0]                   s_axis_tdata,
    // decoded cells
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // note_number, instrument, volume_present, volume, command, command_param,
    // jump_valid, jump_order, jump_row
    output logic [47:0]                   m_axis_tdata,
    // note_kind
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import tped_pkg::*;

    logic         speed_mode_reg;
    logic         in_valid_reg;
    cell_t        in_cell_reg;
    logic         out_valid_reg;
    result_t      out_reg;
    track_state_t state_reg;
    track_state_t state_next;
    result_t      result_next;
    logic         s_accept;
    logic         out_load;
    logic         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_SPEED_MODE) ? {31'h0, speed_mode_reg} : 32'h0;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    tped_decode u_decode (
        .entry             (in_cell_reg),
        .state             (state_reg),
        .speed_divide_mode (speed_mode_reg),
        .result            (result_next),
        .state_next        (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_mode_reg          <= 1'b0;
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.cell_cnt      <= '0;
            state_reg.break_row_min <= ROW_MIN_INIT;
            state_reg.jump_target   <= 8'h00;
            state_reg.jump_seen     <= 1'b0;
        end else begin
            if (cfg_write && paddr == ADDR_SPEED_MODE) begin
                speed_mode_reg <= pwdata[0];
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cell_reg <= cell_t'(s_axis_tdata);
        end
        if (out_load) begin
            out_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.note_kind;
    assign m_axis_tlast  = out_reg.pattern_end;
    assign m_axis_tdata  = {out_reg.jump_row, out_reg.jump_order, out_reg.jump_valid,
                            out_reg.command_param, out_reg.command, out_reg.volume,
                            out_reg.volume_present, out_reg.instrument,
                            out_reg.note_number};

`ifndef SYNTHESIS
    a_jump_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !out_reg.jump_valid
            && out_reg.jump_order == 8'h00 && out_reg.jump_row == 6'd0)
        else $error("jump fields set on a cell that is not the pattern end");

    a_none_has_zero_param: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_reg.command == FX_NONE |-> out_reg.command_param == 8'h00)
        else $error("command none with nonzero parameter");

    a_state_clears_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && result_next.pattern_end |=> state_reg.cell_cnt == '0
            && state_reg.break_row_min == ROW_MIN_INIT && !state_reg.jump_seen)
        else $error("tracking state not cleared after pattern end");

    a_counter_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> $stable(state_reg))
        else $error("tracking state changed without a decoded cell");

    a_volume_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !out_reg.volume_present |-> out_reg.volume == 7'd0)
        else $error("volume nonzero while not present");
`endif

endmodule

FILE: sv/tped_decode.sv
// Combinational decode of one pattern cell plus next tracking state.
// Depends on tped_pkg.
module tped_decode (
    input  tped_pkg::cell_t        entry,
    input  tped_pkg::track_state_t state,
    input  logic                   speed_divide_mode,
    output tped_pkg::result_t      result,
    output tped_pkg::track_state_t state_next
);
    import tped_pkg::*;

    logic [3:0]   hi_nib;
    logic [3:0]   lo_nib;
    logic [7:0]   bcd_val;
    logic [6:0]   vol_raw;
    logic [3:0]   cmd;
    logic [7:0]   par;
    logic         last;
    track_state_t upd;

    assign hi_nib  = entry.effect_param[7:4];
    assign lo_nib  = entry.effect_param[3:0];
    assign bcd_val = {1'b0, hi_nib, 3'b000} + {3'b000, hi_nib, 1'b0} + {4'h0, lo_nib};
    assign vol_raw = {entry.vol_cmd_byte[7:4], entry.instr_vol_byte[2:0]};
    assign last    = (state.cell_cnt == CNT_W'(CELLS_PER_PATTERN - 1));

    always_comb begin
        result = '0;
        if (entry.note_byte == NOTE_CUT_A || entry.note_byte == NOTE_CUT_B) begin
            result.note_kind = KIND_CUT;
        end else if (entry.note_byte < NOTE_CUT_B) begin
            result.note_kind   = KIND_NOTE;
            // octave*12 + semitone + 37
            result.note_number = {1'b0, entry.note_byte[7:4], 3'b000}
                               + {2'b00, entry.note_byte[7:4], 2'b00}
                               + {4'h0, entry.note_byte[3:0]} + NOTE_BASE;
        end

        result.instrument = entry.instr_vol_byte[7:3];
        if (vol_raw <= VOL_MAX) begin
            result.volume_present = 1'b1;
            result.volume         = vol_raw;
        end

        upd = state;
        cmd = effect_lookup(entry.vol_cmd_byte[3:0]);
        par = entry.effect_param;
        if (cmd == FX_VOLSLIDE) begin
            par = (lo_nib != 4'h0) ? {4'h0, lo_nib} : {hi_nib, 4'h0};
        end else if (cmd == FX_BREAK) begin
            par = bcd_val;
            if (bcd_val < {2'b00, state.break_row_min}) begin
                upd.break_row_min = bcd_val[5:0];
            end
        end else if (cmd == FX_JUMP) begin
            upd.jump_target   = entry.effect_param;
            upd.jump_seen     = 1'b1;
            upd.break_row_min = ROW_MIN_INIT;
            cmd               = FX_NONE;
        end else if (cmd != FX_TREMOR) begin
            if (cmd == FX_SPEED && speed_divide_mode) begin
                par = {4'h0, hi_nib};
            end
            if (par == 8'h00) begin
                cmd = FX_NONE;
            end
        end
        if (cmd == FX_NONE) begin
            par = 8'h00;
        end
        result.command       = cmd;
        result.command_param = par;

        result.pattern_end = last;
        if (last && upd.jump_seen) begin
            result.jump_valid = 1'b1;
            result.jump_order = upd.jump_target;
            result.jump_row   = upd.break_row_min;
        end

        state_next = upd;
        if (last) begin
            state_next.cell_cnt      = '0;
            state_next.break_row_min = ROW_MIN_INIT;
            state_next.jump_target   = 8'h00;
            state_next.jump_seen     = 1'b0;
        end else begin
            state_next.cell_cnt = state.cell_cnt + CNT_W'(1);
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench for tracker_pattern_entry_decoder_top: random and directed pattern cells,
// with a cell-by-cell decode predictor and scoreboard. Depends on tped_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
    import tped_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class decoded_cell_board;
        result_t     expected_cells[$];
        bit          divide_speed;
        int unsigned cell_idx;
        int unsigned row_floor;
        logic [7:0]  jump_dest;
        bit          jump_hit;
        int          errors;
        int          checked;
        int          ends;
        int          jump_ends;

        function new();
            divide_speed = 1'b0;
            cell_idx     = 0;
            row_floor    = ROW_MIN_INIT;
            jump_dest    = '0;
            jump_hit     = 1'b0;
            errors       = 0;
            checked      = 0;
            ends         = 0;
            jump_ends    = 0;
        endfunction

        // Decode one accepted cell and queue the expected result.
        function void note_cell(cell_t c);
            result_t     r;
            logic [3:0]  idx;
            logic [3:0]  cmd;
            logic [7:0]  par;
            logic [6:0]  vol;
            int unsigned brk;
            bit          last;
            r = '0;
            if (c.note_byte == NOTE_CUT_A || c.note_byte == NOTE_CUT_B) begin
                r.note_kind = KIND_CUT;
            end else if (c.note_byte < NOTE_CUT_B) begin
                r.note_kind   = KIND_NOTE;
                r.note_number = c.note_byte[7:4] * 8'd12 + c.note_byte[3:0] + NOTE_BASE;
            end else begin
                r.note_kind = KIND_NONE;
            end
            r.instrument = c.instr_vol_byte[7:3];
            vol = {c.vol_cmd_byte[7:4], c.instr_vol_byte[2:0]};
            if (vol <= VOL_MAX) begin
                r.volume_present = 1'b1;
                r.volume         = vol;
            end
            idx = c.vol_cmd_byte[3:0];
            cmd = (idx > FX_ARPEGGIO) ? FX_NONE : idx;
            par = c.effect_param;
            case (cmd)
                FX_VOLSLIDE: begin
                    par = (par[3:0] != 4'h0) ? {4'h0, par[3:0]} : {par[7:4], 4'h0};
                end
                FX_BREAK: begin
                    brk = par[7:4] * 10 + par[3:0];
                    par = brk[7:0];
                    if (brk < row_floor)
                        row_floor = brk;
                end
                FX_JUMP: begin
                    jump_dest = c.effect_param;
                    jump_hit  = 1'b1;
                    row_floor = ROW_MIN_INIT;
                    cmd       = FX_NONE;
                end
                FX_TREMOR: ;
                default: begin
                    if (cmd == FX_SPEED && divide_speed)
                        par = par >> 4;
                    if (par == 8'h00)
                        cmd = FX_NONE;
                end
            endcase
            if (cmd == FX_NONE)
                par = 8'h00;
            r.command       = cmd;
            r.command_param = par;
            last = (cell_idx + 1 >= CELLS_PER_PATTERN);
            r.pattern_end = last;
            if (last && jump_hit) begin
                r.jump_valid = 1'b1;
                r.jump_order = jump_dest;
                r.jump_row   = row_floor[5:0];
            end
            if (last) begin
                cell_idx  = 0;
                row_floor = ROW_MIN_INIT;
                jump_dest = '0;
                jump_hit  = 1'b0;
            end else begin
                cell_idx++;
            end
            expected_cells.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned seen);
            if (want != seen) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s expected %0d, actual %0d", $time, field, want, seen);
            end
        endfunction

        function void check_cell(result_t got);
            result_t want;
            if (expected_cells.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_cells.pop_front();
            checked++;
            if (got.pattern_end) ends++;
            if (got.pattern_end && got.jump_valid) jump_ends++;
            compare_field("note_kind", want.note_kind, got.note_kind);
            compare_field("note_number", want.note_number, got.note_number);
            compare_field("instrument", want.instrument, got.instrument);
            compare_field("volume_present", want.volume_present, got.volume_present);
            compare_field("volume", want.volume, got.volume);
            compare_field("command", want.command, got.command);
            compare_field("command_param", want.command_param, got.command_param);
            compare_field("pattern_end", want.pattern_end, got.pattern_end);
            compare_field("jump_valid", want.jump_valid, got.jump_valid);
            compare_field("jump_order", want.jump_order, got.jump_order);
            compare_field("jump_row", want.jump_row, got.jump_row);
        endfunction
    endclass

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [31:0]          pwdata        = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    decoded_cell_board board;
    bit          steady     = 1'b0;
    int unsigned cells_sent = 0;
    int          jump_mix   = 0;
    int unsigned cycles     = 0;

    tracker_pattern_entry_decoder_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got                = '0;
            got.note_kind      = m_axis_tuser;
            got.note_number    = m_axis_tdata[7:0];
            got.instrument     = m_axis_tdata[12:8];
            got.volume_present = m_axis_tdata[13];
            got.volume         = m_axis_tdata[20:14];
            got.command        = m_axis_tdata[24:21];
            got.command_param  = m_axis_tdata[32:25];
            got.jump_valid     = m_axis_tdata[33];
            got.jump_order     = m_axis_tdata[41:34];
            got.jump_row       = m_axis_tdata[47:42];
            got.pattern_end    = m_axis_tlast;
            board.check_cell(got);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic cell_t mk_cell(input logic [7:0] nb, input logic [7:0] iv,
                                      input logic [3:0] vhi, input logic [3:0] idx,
                                      input logic [7:0] p);
        cell_t c;
        c.note_byte      = nb;
        c.instr_vol_byte = iv;
        c.vol_cmd_byte   = {vhi, idx};
        c.effect_param   = p;
        return c;
    endfunction

    // Breaks are frequent and mostly valid BCD rows; jump density follows the pattern mix.
    function automatic cell_t rand_cell(input int mix);
        logic [3:0] idx;
        logic [3:0] tens;
        logic [3:0] units;
        logic [7:0] nb;
        logic [7:0] p;
        int         roll;
        roll = $urandom_range(0, 99);
        if (mix != 0 && roll < ((mix == 1) ? 2 : 10)) begin
            idx = FX_JUMP;
        end else if (roll < 35) begin
            idx = FX_BREAK;
        end else begin
            idx = 4'($urandom_range(0, 15));
            if (idx == FX_JUMP && mix == 0)
                idx = FX_NONE;
        end
        p = 8'($urandom_range(0, 255));
        if (idx == FX_BREAK && $urandom_range(0, 1) == 1) begin
            tens  = 4'($urandom_range(0, 6));
            units = 4'($urandom_range(0, 9));
            p     = {tens, units};
        end else if ($urandom_range(0, 7) == 0) begin
            p = 8'h00;
        end
        if ($urandom_range(0, 7) == 0)
            nb = NOTE_CUT_B + 8'($urandom_range(0, 3));
        else
            nb = 8'($urandom_range(0, 255));
        return mk_cell(nb, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), idx, p);
    endfunction

    task automatic send_cell(input cell_t c);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_cell(c);
        cells_sent++;
    endtask

    task automatic run_random(input int count, input int calm);
        for (int i = 0; i < count; i++) begin
            steady = (i < calm);
            if (cells_sent % CELLS_PER_PATTERN == 0)
                jump_mix = $urandom_range(0, 2);
            send_cell(rand_cell(jump_mix));
        end
        steady = 1'b0;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.expected_cells.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_speed_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SPEED_MODE;
        pwdata  <= {31'd0, mode};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.divide_speed = mode;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_speed_mode(1'b0);

        // note, volume and effect corners
        send_cell(mk_cell(8'h00, 8'h00, 4'h0, FX_NONE, 8'h00));
        send_cell(mk_cell(8'hFB, 8'hFF, 4'hF, 4'hF, 8'hFF));
        send_cell(mk_cell(NOTE_CUT_B, 8'h08, 4'h8, FX_SPEED, 8'h06));
        send_cell(mk_cell(NOTE_CUT_A, 8'h01, 4'h8, FX_SPEED, 8'h00));
        send_cell(mk_cell(8'hFD, 8'h10, 4'h1, FX_JUMP, 8'h05));
        send_cell(mk_cell(8'hFF, 8'h22, 4'h2, FX_BREAK, 8'h00));
        send_cell(mk_cell(8'h45, 8'h33, 4'h3, FX_BREAK, 8'h99));
        send_cell(mk_cell(8'h5B, 8'h44, 4'h4, FX_BREAK, 8'h32));
        send_cell(mk_cell(8'h30, 8'h55, 4'h5, FX_VOLSLIDE, 8'h30));
        send_cell(mk_cell(8'h31, 8'h66, 4'h6, FX_VOLSLIDE, 8'hAC));
        send_cell(mk_cell(8'h32, 8'h77, 4'h7, FX_VOLSLIDE, 8'h00));
        send_cell(mk_cell(8'h10, 8'h80, 4'h9, FX_BREAK + 4'd2, 8'h00));
        send_cell(mk_cell(8'h11, 8'h91, 4'hA, FX_BREAK + 4'd2, 8'h12));
        send_cell(mk_cell(8'h12, 8'hA2, 4'hB, FX_VOLSLIDE + 4'd2, 8'h20));
        send_cell(mk_cell(8'h13, 8'hB3, 4'hC, FX_VOLSLIDE + 4'd3, 8'h44));
        send_cell(mk_cell(8'h14, 8'hC4, 4'hD, FX_VOLSLIDE + 4'd4, 8'h00));
        send_cell(mk_cell(8'h15, 8'hD5, 4'hE, FX_TREMOR, 8'h00));
        send_cell(mk_cell(8'h16, 8'hE6, 4'h0, FX_ARPEGGIO, 8'h37));
        send_cell(mk_cell(8'h17, 8'hF7, 4'h1, FX_ARPEGGIO + 4'd1, 8'h55));
        send_cell(mk_cell(8'h18, 8'h0F, 4'h2, FX_ARPEGGIO + 4'd3, 8'hAA));
        send_cell(mk_cell(8'h19, 8'h1E, 4'h3, FX_ARPEGGIO + 4'd5, 8'h01));
        send_cell(mk_cell(8'hF0, 8'h2D, 4'h4, FX_JUMP, 8'hFF));
        send_cell(mk_cell(8'hFA, 8'h3C, 4'h5, FX_BREAK, 8'h65));

        run_random(200, 0);
        settle();
        run_random(200, 0);
        settle();

        write_speed_mode(1'b1);
        send_cell(mk_cell(8'h20, 8'h08, 4'h1, FX_SPEED, 8'h0F));
        send_cell(mk_cell(8'h21, 8'h08, 4'h1, FX_SPEED, 8'h10));
        send_cell(mk_cell(8'h22, 8'h08, 4'h1, FX_SPEED, 8'hF0));
        run_random(400, 250);
        settle();

        write_speed_mode(1'b0);
        run_random(350, 0);
        settle();

        $display("Checked %0d decoded cells, %0d pattern ends (%0d reporting a jump),",
                 board.checked, board.ends, board.jump_ends);
        $display("with speed division both off and on and random stalls on both channels");
        if (board.errors == 0 && board.expected_cells.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
